FILE: rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants for the modular exponentiation unit: default operand
// width and the configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

    // Default width of message, exponent, modulus and result
    localparam int OPERAND_WIDTH_DEF = 31;

    // Configuration register index port width
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register map
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS  = 2'd1;

endpackage : modexp_pkg

`default_nettype wire

FILE: rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial modular multiplier: result = (a * b) mod m, with a, m latched
// at start and b shifted in MSB first, one bit per cycle. Requires a < m or
// a == 1. Busy while the bits of b are shifted in after the start cycle; done
// pulses for one cycle right after that.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_mulmod #(
    parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [OPERAND_WIDTH-1:0] i_a,
    input  wire logic [OPERAND_WIDTH-1:0] i_b,
    input  wire logic [OPERAND_WIDTH-1:0] i_m,
    output logic                          o_done,
    output logic [OPERAND_WIDTH-1:0]      o_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [W-1:0]  r_a,    n_a;
    logic [W-1:0]  r_bits, n_bits;
    logic [W-1:0]  r_m,    n_m;
    logic [W-1:0]  r_acc,  n_acc;

    logic [W+2:0]  step_sum, step_d1, step_d2;
    logic [W-1:0]  acc_step;

    // One digit: acc = (2*acc + bit*a) mod m, sum below 3m so two trial subtracts
    always_comb begin
        step_sum = {2'b00, r_acc, 1'b0} + (r_bits[W-1] ? {3'b000, r_a} : '0);
        step_d1  = step_sum - {3'b000, r_m};
        step_d2  = step_sum - {2'b00, r_m, 1'b0};
        if (!step_d2[W+2]) begin
            acc_step = step_d2[W-1:0];
        end else if (!step_d1[W+2]) begin
            acc_step = step_d1[W-1:0];
        end else begin
            acc_step = step_sum[W-1:0];
        end
    end

    // Sequencing of the W digits
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_bits = r_bits;
        n_m    = r_m;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_a    = i_a;
            n_bits = i_b;
            n_m    = i_m;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc  = acc_step;
            n_bits = {r_bits[W-2:0], 1'b0};
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_bits <= n_bits;
        r_m    <= n_m;
        r_acc  <= n_acc;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

    // Checks
    a_no_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("multiplier restarted while busy");

    a_acc_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy || r_done) |-> (r_acc < r_m))
        else $error("accumulator not reduced");

    a_done_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running product");

endmodule : modexp_mulmod

`default_nettype wire

FILE: rtl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Computes message^exponent mod modulus by right-to-left square-and-multiply
// on one bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One item at a time. Every modular product runs on the bit-serial multiplier
// at one bit per cycle (W = OPERAND_WIDTH). For an exponent of bit length k+1
// with p one bits, one product reduces the message, k products square and p
// multiply, and each exponent bit passes through the STEP and SHIFT states.
// The unit is ready again once the result is loaded into the output register.
// Exponent zero gives 1 mod modulus after the reduction product, and a
// modulus of zero returns 0 without running the multiplier. A finished
// result waits in an output register, so the next message is taken while
// it is still unread; a second finished result holds the input off until
// the first one is read. The user must write exponent and modulus through
// the config port only while idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_unit #(
    parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // config write
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [OPERAND_WIDTH-1:0]              i_cfg_data,
    // message in
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [OPERAND_WIDTH-1:0]              i_message_value,
    // result out
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [OPERAND_WIDTH-1:0]                   o_power_result
);

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_REDUCE = 7'b0000010,
        S_STEP   = 7'b0000100,
        S_MULR   = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_SQR    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state       r_state, n_state;
    logic [W-1:0] r_exponent, n_exponent;
    logic [W-1:0] r_modulus,  n_modulus;
    logic [W-1:0] r_e,        n_e;
    logic [W-1:0] r_r,        n_r;
    logic [W-1:0] r_b,        n_b;
    logic         r_out_valid, n_out_valid;
    logic [W-1:0] r_out_data,  n_out_data;

    logic         in_beat;
    logic         out_load;
    logic         mul_start;
    logic [W-1:0] mul_a, mul_bits;
    logic         mul_done;
    logic [W-1:0] mul_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Config registers
    always_comb begin
        n_exponent = r_exponent;
        n_modulus  = r_modulus;
        if (i_cfg_valid) begin
            if (i_cfg_index == modexp_pkg::CFG_EXPONENT) begin
                n_exponent = i_cfg_data;
            end else if (i_cfg_index == modexp_pkg::CFG_MODULUS) begin
                n_modulus = i_cfg_data;
            end
        end
    end

    // Multiplier operands: message reduction, r*b, or b*b
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                mul_a    = W'(1);
                mul_bits = i_message_value;
            end
            S_STEP: begin
                mul_a    = r_r;
                mul_bits = r_b;
            end
            default: begin
                mul_a    = r_b;
                mul_bits = r_b;
            end
        endcase
    end

    // Square-and-multiply sequencer
    always_comb begin
        n_state   = r_state;
        n_e       = r_e;
        n_r       = r_r;
        n_b       = r_b;
        mul_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_e = r_exponent;
                    if (r_modulus == '0) begin
                        n_r     = '0;
                        n_state = S_DONE;
                    end else begin
                        mul_start = 1'b1;
                        n_state   = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mul_done) begin
                    n_b     = mul_result;
                    n_r     = (r_modulus == W'(1)) ? '0 : W'(1);
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_e == '0) begin
                    n_state = S_DONE;
                end else if (r_e[0]) begin
                    mul_start = 1'b1;
                    n_state   = S_MULR;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_MULR: begin
                if (mul_done) begin
                    n_r     = mul_result;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_e = {1'b0, r_e[W-1:1]};
                if (r_e[W-1:1] != '0) begin
                    mul_start = 1'b1;
                    n_state   = S_SQR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SQR: begin
                if (mul_done) begin
                    n_b     = mul_result;
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = r_r;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exponent  <= W'(1);
            r_modulus   <= W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exponent  <= n_exponent;
            r_modulus   <= n_modulus;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e        <= n_e;
        r_r        <= n_r;
        r_b        <= n_b;
        r_out_data <= n_out_data;
    end

    modexp_mulmod #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_bits),
        .i_m      (r_modulus),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_out_data;

    // Checks
    a_done_in_mul_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_REDUCE || r_state == S_MULR || r_state == S_SQR))
        else $error("product finished outside a multiply state");

    a_operands_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_b < r_modulus && r_r < r_modulus))
        else $error("working values not reduced");

    a_result_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> ((r_modulus == '0) ? (r_r == '0) : (r_r < r_modulus)))
        else $error("result out of range");

endmodule : modular_exponentiation_unit

`default_nettype wire
